[rtl/fixed_timestep_accumulator_macros.svh]
// Assertion macros shared by the accumulator RTL.
`ifndef FIXED_TIMESTEP_ACCUMULATOR_MACROS_SVH
`define FIXED_TIMESTEP_ACCUMULATOR_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define FTA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define FTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/fta_pkg.sv]
// Shared constants and types of the fixed timestep accumulator.
package fta_pkg;

   // Fixed point and accumulator sizing
   localparam int FRACTION_BITS = 16;
   localparam int TIME_WIDTH    = 64;

   // Field widths
   localparam int STEP_W   = 32;
   localparam int FRAC_W   = 24;
   localparam int SUB_W    = 5;
   localparam int TOTAL_W  = 63;
   localparam int INT_BITS = FRAC_W - FRACTION_BITS;

   // Divider: the shifted divisor spans the step width plus the quotient width
   localparam int DIV_W   = STEP_W + FRAC_W;
   localparam int UNIT_W  = (TIME_WIDTH > DIV_W) ? TIME_WIDTH : DIV_W;
   localparam int QCNT_W  = $clog2(FRAC_W);

   localparam int SUBSTEP_LIMIT = 16;

   // Register reset values
   localparam logic [STEP_W-1:0] FIXED_STEP_RESET = STEP_W'(16666667);
   localparam logic [STEP_W-1:0] MAX_FRAME_RESET  = STEP_W'(250000000);
   localparam logic [SUB_W-1:0]  MAX_SUB_RESET    = SUB_W'(8);

   // Register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAME  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SUB    = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_ACCUM,
      ST_STEP,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

[rtl/fta_channels.sv]
// Valid/ready channel interfaces of the fixed timestep accumulator.

// Frame delta input channel
interface fta_req_if import fta_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STEP_W-1:0] frame_delta_ns;

   modport source (output valid, output frame_delta_ns, input ready);
   modport sink   (input valid, input frame_delta_ns, output ready);
endinterface

// Step result channel
interface fta_rsp_if import fta_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SUB_W-1:0]   step_count;
   logic [TOTAL_W-1:0] sim_tick;
   logic [TOTAL_W-1:0] sim_time_ns;
   logic [FRAC_W-1:0]  blend_fraction;
   logic               was_first_frame;

   modport source (output valid, output step_count, output sim_tick, output sim_time_ns,
                   output blend_fraction, output was_first_frame, input ready);
   modport sink   (input valid, input step_count, input sim_tick, input sim_time_ns,
                   input blend_fraction, input was_first_frame, output ready);
endinterface

// Register write channel
interface fta_csr_if import fta_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [STEP_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/fta_cmp_sub.sv]
// Shared compare and subtract unit used by the clamp, substep, check and divide steps.
module fta_cmp_sub import fta_pkg::*; (
   input  logic [UNIT_W-1:0] op_a,
   input  logic [UNIT_W-1:0] op_b,
   output logic [UNIT_W-1:0] diff,
   output logic              a_ge_b
);

   logic [UNIT_W:0] wide_diff;

   // Subtract with one extra bit: the borrow tells the compare result
   assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
   assign diff      = wide_diff[UNIT_W-1:0];
   assign a_ge_b    = ~wide_diff[UNIT_W];

endmodule

[rtl/fixed_timestep_accumulator.sv]
// Top level of the fixed timestep accumulator: sequencer, state and result register.
//
//   channel   dir   transfer when          payload
//   req_chan  in    valid && ready         frame_delta_ns
//   rsp_chan  out   valid && ready         step_count, sim_tick, sim_time_ns,
//                                          blend_fraction, was_first_frame
//   csr_chan  in    valid (ready held 1)   index, data
//
// Frame states run clamp, accumulate, substep loop, check, divide, finish; an arming
// frame starts at check. A zero step size or a saturated fraction skips the division.
// The clamp, substep loop, check and restoring division share one compare/subtract unit.
// Reset clears the accumulator, tick, time and armed flag and reloads the registers.
// The next frame is taken while a result waits in the output register; a frame that
// finishes before that result is taken holds in its last state.
`include "fixed_timestep_accumulator_macros.svh"

module fixed_timestep_accumulator import fta_pkg::*; (
   input  logic clock,
   input  logic reset,
   fta_req_if.sink   req_chan,
   fta_rsp_if.source rsp_chan,
   fta_csr_if.sink   csr_chan
);

   // Configuration registers
   logic [STEP_W-1:0]     fixed_step_ff, fixed_step_in;
   logic [STEP_W-1:0]     max_frame_ff, max_frame_in;
   logic [SUB_W-1:0]      max_sub_ff, max_sub_in;

   // Sequencer and model state
   state_type             state_ff, state_in;
   logic                  armed_ff, armed_in;
   logic                  first_ff, first_in;
   logic [STEP_W-1:0]     delta_ff, delta_in;
   logic [TIME_WIDTH-1:0] acc_ff, acc_in;
   logic [TOTAL_W-1:0]    time_ff, time_in;
   logic [TOTAL_W-1:0]    tick_ff, tick_in;
   logic [SUB_W-1:0]      cap_ff, cap_in;
   logic [SUB_W-1:0]      steps_ff, steps_in;

   // Divider registers
   logic [DIV_W-1:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]      div_ff, div_in;
   logic [FRAC_W-1:0]     frac_ff, frac_in;
   logic [QCNT_W-1:0]     qcnt_ff, qcnt_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SUB_W-1:0]      rsp_steps_ff;
   logic [TOTAL_W-1:0]    rsp_tick_ff;
   logic [TOTAL_W-1:0]    rsp_time_ff;
   logic [FRAC_W-1:0]     rsp_frac_ff;
   logic                  rsp_first_ff;

   // Shared unit ports and handshake terms
   logic [UNIT_W-1:0]     unit_a, unit_b, unit_diff;
   logic                  unit_ge;
   logic                  req_xfer;
   logic                  out_free;
   logic                  step_go;
   logic [TIME_WIDTH:0]   acc_sum;

   fta_cmp_sub u_cmp_sub (
      .op_a   (unit_a),
      .op_b   (unit_b),
      .diff   (unit_diff),
      .a_ge_b (unit_ge)
   );

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign step_go  = unit_ge && (steps_ff < cap_ff);
   assign acc_sum  = {1'b0, acc_ff} + (TIME_WIDTH + 1)'(delta_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = armed_ff ? ST_CLAMP : ST_CHECK;
            end
         end
         ST_CLAMP:  state_in = ST_ACCUM;
         ST_ACCUM:  state_in = ST_STEP;
         ST_STEP: begin
            if (!step_go) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((fixed_step_ff == '0) || unit_ge) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (qcnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs and shared unit operand select
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      csr_chan.ready = 1'b1;
      unit_a = '0;
      unit_b = '0;
      case (state_ff)
         ST_CLAMP: begin
            unit_a = UNIT_W'(delta_ff);
            unit_b = UNIT_W'(max_frame_ff);
         end
         ST_STEP: begin
            unit_a = UNIT_W'(acc_ff);
            unit_b = UNIT_W'(fixed_step_ff);
         end
         ST_CHECK: begin
            unit_a = UNIT_W'(acc_ff);
            unit_b = UNIT_W'(fixed_step_ff) << INT_BITS;
         end
         ST_DIVIDE: begin
            unit_a = UNIT_W'(rem_ff);
            unit_b = UNIT_W'(div_ff);
         end
         default: begin
            unit_a = '0;
            unit_b = '0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      fixed_step_in = fixed_step_ff;
      max_frame_in  = max_frame_ff;
      max_sub_in    = max_sub_ff;
      armed_in      = armed_ff;
      first_in      = first_ff;
      delta_in      = delta_ff;
      acc_in        = acc_ff;
      time_in       = time_ff;
      tick_in       = tick_ff;
      cap_in        = cap_ff;
      steps_in      = steps_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      frac_in       = frac_ff;
      qcnt_in       = qcnt_ff;
      rsp_valid_in  = rsp_valid_ff;

      // Drop the result once the sink takes it
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_FIXED_STEP: fixed_step_in = csr_chan.data;
            CSR_MAX_FRAME:  max_frame_in  = csr_chan.data;
            CSR_MAX_SUB:    max_sub_in    = csr_chan.data[SUB_W-1:0];
            default: begin
               fixed_step_in = fixed_step_ff;
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               delta_in = req_chan.frame_delta_ns;
               first_in = !armed_ff;
               armed_in = 1'b1;
               steps_in = '0;
               cap_in   = (max_sub_ff > SUB_W'(SUBSTEP_LIMIT)) ?
                          SUB_W'(SUBSTEP_LIMIT) : max_sub_ff;
            end
         end
         ST_CLAMP: begin
            // Clamp the delta to the frame limit
            if (unit_ge) begin
               delta_in = max_frame_ff;
            end
         end
         ST_ACCUM: begin
            // Saturating add into the accumulator
            acc_in = acc_sum[TIME_WIDTH] ? '1 : acc_sum[TIME_WIDTH-1:0];
         end
         ST_STEP: begin
            // Take one fixed step off the accumulator
            if (step_go) begin
               acc_in   = unit_diff[TIME_WIDTH-1:0];
               time_in  = time_ff + TOTAL_W'(fixed_step_ff);
               tick_in  = tick_ff + TOTAL_W'(1);
               steps_in = steps_ff + SUB_W'(1);
            end
         end
         ST_CHECK: begin
            // Zero step gives zero, an integer part past range saturates
            if (fixed_step_ff == '0) begin
               frac_in = '0;
            end else if (unit_ge) begin
               frac_in = '1;
            end else begin
               frac_in = '0;
               rem_in  = DIV_W'(acc_ff) << FRACTION_BITS;
               div_in  = DIV_W'(fixed_step_ff) << (FRAC_W - 1);
               qcnt_in = QCNT_W'(FRAC_W - 1);
            end
         end
         ST_DIVIDE: begin
            // One restoring division bit per cycle
            if (unit_ge) begin
               rem_in = unit_diff[DIV_W-1:0];
            end
            frac_in = {frac_ff[FRAC_W-2:0], unit_ge};
            div_in  = div_ff >> 1;
            qcnt_in = qcnt_ff - QCNT_W'(1);
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff;
         end
      endcase
   end

   // Control and model state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         armed_ff      <= 1'b0;
         acc_ff        <= '0;
         time_ff       <= '0;
         tick_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         fixed_step_ff <= FIXED_STEP_RESET;
         max_frame_ff  <= MAX_FRAME_RESET;
         max_sub_ff    <= MAX_SUB_RESET;
      end else begin
         state_ff      <= state_in;
         armed_ff      <= armed_in;
         acc_ff        <= acc_in;
         time_ff       <= time_in;
         tick_ff       <= tick_in;
         rsp_valid_ff  <= rsp_valid_in;
         fixed_step_ff <= fixed_step_in;
         max_frame_ff  <= max_frame_in;
         max_sub_ff    <= max_sub_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      first_ff <= first_in;
      delta_ff <= delta_in;
      cap_ff   <= cap_in;
      steps_ff <= steps_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      frac_ff  <= frac_in;
      qcnt_ff  <= qcnt_in;
   end

   // Load the result register when the frame finishes
   always_ff @(posedge clock) begin
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_steps_ff <= first_ff ? '0 : steps_ff;
         rsp_tick_ff  <= tick_ff;
         rsp_time_ff  <= time_ff;
         rsp_frac_ff  <= frac_ff;
         rsp_first_ff <= first_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.step_count      = rsp_steps_ff;
   assign rsp_chan.sim_tick        = rsp_tick_ff;
   assign rsp_chan.sim_time_ns     = rsp_time_ff;
   assign rsp_chan.blend_fraction  = rsp_frac_ff;
   assign rsp_chan.was_first_frame = rsp_first_ff;

   // Assertions
   `FTA_ASSERT_NEXT(a_arm_to_check, clock, reset, req_xfer && !armed_ff,
                    (state_ff == ST_CHECK) && first_ff,
                    "arming frame must go straight to the fraction check")
   `FTA_ASSERT_NOW(a_steps_capped, clock, reset, state_ff == ST_STEP,
                   (steps_ff <= cap_ff) && (cap_ff <= SUB_W'(SUBSTEP_LIMIT)),
                   "substep count ran past its cap")
   `FTA_ASSERT_NOW(a_div_bound, clock, reset, state_ff == ST_DIVIDE,
                   rem_ff < (div_ff << 1), "division remainder out of bound")
   `FTA_ASSERT_NEXT(a_finish_loads, clock, reset, (state_ff == ST_FINISH) && out_free,
                    rsp_valid_ff && (state_ff == ST_IDLE),
                    "finished frame did not reach the result register")
   `FTA_ASSERT_NOW(a_busy_armed, clock, reset, state_ff != ST_IDLE, armed_ff,
                   "frame in progress while not armed")

endmodule

[bench/tb_top.sv]
// Self-checking bench for the fixed timestep accumulator: directed and random frames.
module tb_top import fta_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_FRAMES  = 1850;
   localparam int CALM_FRAMES    = 200;
   localparam int SETTLE_CYCLES  = 60;
   localparam logic [TIME_WIDTH-1:0] ACC_TOP     = {TIME_WIDTH{1'b1}};
   localparam logic [TIME_WIDTH-1:0] BLEED_LEVEL = 64'd1 << 34;

   typedef struct packed {
      logic [SUB_W-1:0]   step_count;
      logic [TOTAL_W-1:0] sim_tick;
      logic [TOTAL_W-1:0] sim_time_ns;
      logic [FRAC_W-1:0]  blend_fraction;
      logic               was_first_frame;
   } frame_result_type;

   logic clock;
   logic reset;

   fta_req_if req_if ();
   fta_rsp_if rsp_if ();
   fta_csr_if csr_if ();

   fixed_timestep_accumulator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Register copies used by the predictor
   logic [STEP_W-1:0] step_ns_cfg;
   logic [STEP_W-1:0] frame_cap_cfg;
   logic [SUB_W-1:0]  substep_cap_cfg;

   // Predictor state
   bit                    is_armed;
   logic [TIME_WIDTH-1:0] accum_ns;
   logic [TOTAL_W-1:0]    sim_time_total;
   logic [TOTAL_W-1:0]    tick_count;

   frame_result_type due_results[$];
   int               fail_count;
   int               stall_cycles;

   // Idle controls shared by both sides
   bit          calm;
   int unsigned req_idle_odds;
   int unsigned rsp_idle_odds;

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Accumulator over step size in unsigned fixed point, saturating
   function automatic logic [FRAC_W-1:0] blend_of_accum(input logic [TIME_WIDTH-1:0] acc,
                                                         input logic [STEP_W-1:0] step);
      logic [63:0] whole;
      logic [63:0] rem;
      logic [63:0] frac;
      if (step == '0) return '0;
      whole = acc / step;
      rem   = acc % step;
      if (whole > 64'((1 << INT_BITS) - 1)) return '1;
      frac = (whole << FRACTION_BITS) + ((rem << FRACTION_BITS) / step);
      if (frac > 64'({FRAC_W{1'b1}})) return '1;
      return frac[FRAC_W-1:0];
   endfunction

   // Advance the predictor by one frame and return the result it causes
   function automatic frame_result_type advance_frame(input logic [STEP_W-1:0] delta);
      frame_result_type      res;
      logic [TIME_WIDTH-1:0] frame_ns;
      int unsigned           cap;
      int unsigned           steps;
      cap   = (substep_cap_cfg > SUBSTEP_LIMIT) ? SUBSTEP_LIMIT : substep_cap_cfg;
      steps = 0;
      res.was_first_frame = 1'b0;
      if (!is_armed) begin
         // arming frame: delta ignored, no steps
         is_armed = 1'b1;
         res.was_first_frame = 1'b1;
      end else begin
         frame_ns = TIME_WIDTH'((delta < frame_cap_cfg) ? delta : frame_cap_cfg);
         if (accum_ns > ACC_TOP - frame_ns)
            accum_ns = ACC_TOP;
         else
            accum_ns = accum_ns + frame_ns;
         // take whole steps up to the cap
         while (accum_ns >= step_ns_cfg && steps < cap) begin
            accum_ns       = accum_ns - step_ns_cfg;
            sim_time_total = sim_time_total + step_ns_cfg;
            tick_count     = tick_count + 1'b1;
            steps++;
         end
      end
      res.step_count     = SUB_W'(steps);
      res.sim_tick       = tick_count;
      res.sim_time_ns    = sim_time_total;
      res.blend_fraction = blend_of_accum(accum_ns, step_ns_cfg);
      return res;
   endfunction

   // Random frame delta, biased toward step multiples and the clamp
   function automatic logic [STEP_W-1:0] pick_delta();
      logic [63:0] near;
      case ($urandom_range(5, 0))
         0, 1: pick_delta = $urandom;
         2: begin
            near = 64'(step_ns_cfg) * $urandom_range(4, 0) + $urandom_range(1000, 0);
            pick_delta = (near > 64'hFFFF_FFFF) ? '1 : near[STEP_W-1:0];
         end
         3: pick_delta = $urandom_range(255, 0);
         4: pick_delta = frame_cap_cfg ^ STEP_W'($urandom_range(3, 0));
         default: pick_delta = $urandom_range(1, 0) ? '0 : '1;
      endcase
   endfunction

   function automatic logic [STEP_W-1:0] pick_step();
      case ($urandom_range(7, 0))
         0: pick_step = '0;
         1: pick_step = 1;
         2: pick_step = FIXED_STEP_RESET;
         3: pick_step = '1;
         4: pick_step = $urandom;
         5: pick_step = $urandom_range(1000000, 1);
         default: pick_step = $urandom_range(100000000, 1000000);
      endcase
   endfunction

   function automatic logic [STEP_W-1:0] pick_frame_cap(input logic [STEP_W-1:0] step);
      logic [63:0] span;
      case ($urandom_range(5, 0))
         0: pick_frame_cap = '0;
         1: pick_frame_cap = '1;
         2: pick_frame_cap = MAX_FRAME_RESET;
         3: pick_frame_cap = $urandom;
         default: begin
            span = 64'(step) * $urandom_range(20, 1);
            pick_frame_cap = (span > 64'hFFFF_FFFF) ? '1 : span[STEP_W-1:0];
         end
      endcase
   endfunction

   // Substep cap with random upper data bits, which the register drops
   function automatic logic [STEP_W-1:0] pick_substeps();
      logic [SUB_W-1:0] cap;
      case ($urandom_range(4, 0))
         0: cap = '0;
         1: cap = SUB_W'(SUBSTEP_LIMIT);
         2: cap = '1;
         default: cap = SUB_W'($urandom_range(31, 0));
      endcase
      if ($urandom_range(1, 0))
         pick_substeps = {(STEP_W - SUB_W)'($urandom), cap};
      else
         pick_substeps = STEP_W'(cap);
   endfunction

   // Send one frame delta and record what it must produce
   task automatic send_frame(input logic [STEP_W-1:0] delta);
      if (!calm && req_idle_odds != 0 && $urandom_range(req_idle_odds - 1, 0) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(15, 1)) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.frame_delta_ns <= delta;
      do @(posedge clock); while (!req_if.ready);
      due_results.push_back(advance_frame(delta));
   endtask

   // Drop valid and wait until every pending result has arrived
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
   endtask

   // Write one register, keeping valid high for the next write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [STEP_W-1:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_FIXED_STEP: step_ns_cfg = val;
         CSR_MAX_FRAME:  frame_cap_cfg = val;
         default:        substep_cap_cfg = val[SUB_W-1:0];
      endcase
   endtask

   // Reprogram all registers once the block is idle
   task automatic program_regs(input logic [STEP_W-1:0] step_val,
                               input logic [STEP_W-1:0] frame_val,
                               input logic [STEP_W-1:0] sub_val);
      drain_results();
      write_reg(CSR_FIXED_STEP, step_val);
      write_reg(CSR_MAX_FRAME, frame_val);
      write_reg(CSR_MAX_SUB, sub_val);
      csr_if.valid <= 1'b0;
   endtask

   // First frame only arms, whatever its delta
   task automatic test_arming_frame();
      send_frame('1);
      send_frame('0);
   endtask

   // Delta extremes against the reset clamp and step size
   task automatic test_frame_clamp();
      send_frame('1);
      send_frame(MAX_FRAME_RESET);
      send_frame(FIXED_STEP_RESET - 1);
      send_frame(FIXED_STEP_RESET);
   endtask

   // Cap values: above range, at the limit, zero and one
   task automatic test_substep_cap();
      program_regs(1000, '1, 31);
      send_frame('1);
      program_regs(1000, '1, SUBSTEP_LIMIT);
      send_frame(16000);
      program_regs(1000, '1, 0);
      send_frame(5000);
      program_regs(1000, '1, 1);
      send_frame(999);
   endtask

   // Zero step size always takes the capped count
   task automatic test_zero_step();
      program_regs('0, '1, 5);
      send_frame($urandom);
      send_frame('0);
      program_regs('0, '0, 17);
      send_frame('1);
   endtask

   // Bring the accumulator down, then push the fraction into saturation
   task automatic test_fraction_saturation();
      program_regs('1, '0, SUBSTEP_LIMIT);
      send_frame('0);
      send_frame('0);
      program_regs('1, '1, 0);
      send_frame(32'h8000_0000);
      program_regs(1, '1, 0);
      send_frame('1);
      program_regs(FIXED_STEP_RESET, MAX_FRAME_RESET, MAX_SUB_RESET);
      send_frame(FIXED_STEP_RESET + (FIXED_STEP_RESET >> 1));
   endtask

   // Random phases under random register settings and idling
   task automatic test_random_frames();
      int                sent;
      int                phase_len;
      logic [STEP_W-1:0] step_val;
      logic [STEP_W-1:0] frame_val;
      sent = 0;
      while (sent < RANDOM_FRAMES) begin
         // bleed a grown accumulator so later phases see small remainders
         if (accum_ns > BLEED_LEVEL) begin
            program_regs('1, '0, SUBSTEP_LIMIT);
            while (accum_ns >= 64'hFFFF_FFFF) send_frame($urandom);
         end
         step_val  = pick_step();
         frame_val = pick_frame_cap(step_val);
         program_regs(step_val, frame_val, pick_substeps());
         calm = (sent >= RANDOM_FRAMES - CALM_FRAMES);
         case ($urandom_range(3, 0))
            0: begin req_idle_odds = 0; rsp_idle_odds = 0; end
            1: begin req_idle_odds = 2; rsp_idle_odds = 0; end
            2: begin req_idle_odds = 0; rsp_idle_odds = 2; end
            default: begin req_idle_odds = 4; rsp_idle_odds = 4; end
         endcase
         phase_len = $urandom_range(90, 30);
         for (int i = 0; i < phase_len && sent < RANDOM_FRAMES; i++) begin
            send_frame(pick_delta());
            sent++;
         end
      end
   endtask

   // Result ready with random stall bursts
   initial begin
      rsp_if.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!calm && rsp_idle_odds != 0 && $urandom_range(rsp_idle_odds - 1, 0) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Compare each result transfer with the oldest pending one
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (due_results.size() == 0) begin
            $error("result transfer with no frame pending");
            fail_count++;
         end else begin
            want = due_results.pop_front();
            if (rsp_if.step_count !== want.step_count) begin
               $error("step_count: expected %0d, actual %0d", want.step_count,
                      rsp_if.step_count);
               fail_count++;
            end
            if (rsp_if.sim_tick !== want.sim_tick) begin
               $error("sim_tick: expected %0d, actual %0d", want.sim_tick, rsp_if.sim_tick);
               fail_count++;
            end
            if (rsp_if.sim_time_ns !== want.sim_time_ns) begin
               $error("sim_time_ns: expected %0d, actual %0d", want.sim_time_ns,
                      rsp_if.sim_time_ns);
               fail_count++;
            end
            if (rsp_if.blend_fraction !== want.blend_fraction) begin
               $error("blend_fraction: expected %0h, actual %0h", want.blend_fraction,
                      rsp_if.blend_fraction);
               fail_count++;
            end
            if (rsp_if.was_first_frame !== want.was_first_frame) begin
               $error("was_first_frame: expected %0d, actual %0d", want.was_first_frame,
                      rsp_if.was_first_frame);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Test sequence
   initial begin
      req_if.valid          <= 1'b0;
      req_if.frame_delta_ns <= '0;
      csr_if.valid          <= 1'b0;
      csr_if.index          <= CSR_FIXED_STEP;
      csr_if.data           <= '0;
      reset                 <= 1'b1;
      stall_cycles          = 0;
      fail_count            = 0;
      calm                  = 1'b0;
      req_idle_odds         = 4;
      rsp_idle_odds         = 4;
      step_ns_cfg           = FIXED_STEP_RESET;
      frame_cap_cfg         = MAX_FRAME_RESET;
      substep_cap_cfg       = MAX_SUB_RESET;
      is_armed              = 1'b0;
      accum_ns              = '0;
      sim_time_total        = '0;
      tick_count            = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_arming_frame();
      test_frame_clamp();
      test_substep_cap();
      test_zero_step();
      test_fraction_saturation();
      test_random_frames();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[fixed_timestep_accumulator.f]
+incdir+rtl
rtl/fta_pkg.sv
rtl/fta_channels.sv
rtl/fta_cmp_sub.sv
rtl/fixed_timestep_accumulator.sv
bench/tb_top.sv
